@@ hw/rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg - shared types, constants and arithmetic helpers
// Calibration layout, queue item and divider side-band types, and the
// wrapping 64-bit multiply helpers used by the pressure path.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam logic [19:0]        SKIP_CODE  = 20'h80000;
  localparam logic [31:0]        T_ROUND    = 32'd128;
  localparam logic [63:0]        P_FINE_OFS = 64'd128000;
  localparam logic [20:0]        P_FULL     = 21'd1048576;
  localparam logic [16:0]        P_SCALE    = 17'd3125;
  localparam logic [63:0]        P_BIAS     = 64'h0000_8000_0000_0000;
  localparam int                 DIV_W      = 64;

  localparam logic [1:0]         ST_OK      = 2'd0;
  localparam logic [1:0]         ST_SKIP    = 2'd1;
  localparam logic [1:0]         ST_ZERO    = 2'd2;

  typedef enum logic [1:0] {
    CFG_TEMP    = 2'd0,
    CFG_PRESS_A = 2'd1,
    CFG_PRESS_B = 2'd2,
    CFG_PRESS_C = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [15:0] press_c;
  } cal_t;

  typedef struct packed {
    logic        skip;
    logic [19:0] adcp;
    logic [31:0] tf;
    logic [31:0] temp;
  } fq_item_t;

  typedef struct packed {
    logic        skip;
    logic        dz;
    logic        neg;
    logic [31:0] temp;
  } side_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } mulp_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [16:0] sx17(input logic [15:0] x);
    return {x[15], x};
  endfunction

  // Low 64 bits of a times a signed 17-bit factor.
  function automatic logic [63:0] mul64x16(input logic [63:0] a, input logic [16:0] b);
    logic signed [49:0] lo;
    logic [31:0]        hi;
    logic [31:0]        b32;
    b32 = {{15{b[16]}}, b};
    lo  = $signed({1'b0, a[31:0]}) * $signed(b);
    hi  = a[63:32] * b32;
    return {{14{lo[49]}}, lo} + {hi, 32'd0};
  endfunction

  // Partial products of a 64x64 product, low 64 bits only.
  function automatic mulp_t mul_part(input logic [63:0] a, input logic [63:0] b);
    mulp_t       r;
    logic [31:0] c1;
    logic [31:0] c2;
    r.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    c1   = a[31:0] * b[63:32];
    c2   = a[63:32] * b[31:0];
    r.cr = c1 + c2;
    return r;
  endfunction

  function automatic logic [63:0] mul_join(input mulp_t p);
    return p.ll + {p.cr, 32'd0};
  endfunction

endpackage

@@ hw/rtl/bpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front - sample capture, classification and temperature path
// Five free-running stages: flag the skipped-sample code, work out the fine
// temperature and the temperature in hundredths of a degree.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [19:0]        adcp,
  input  logic [19:0]        adct,
  input  bpc_pkg::cal_t      cal,
  output logic               push,
  output bpc_pkg::fq_item_t  item
);
  import bpc_pkg::*;

  logic [4:0]  v_r;
  logic        skip0_r, skip1_r, skip2_r, skip3_r, skip4_r;
  logic [19:0] adcp0_r, adcp1_r, adcp2_r, adcp3_r, adcp4_r;
  logic [19:0] adct0_r;
  logic [31:0] pa_r, pb_r, v1_r, m_r, tf3_r, tf4_r, temp4_r;
  logic [31:0] a_c, b_c, bb_c, tf_c, t5_c;
  logic [15:0] t1;
  logic [31:0] t2, t3;

  assign t1 = cal.temp_cal[15:0];
  assign t2 = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
  assign t3 = {{16{cal.temp_cal[47]}}, cal.temp_cal[47:32]};

  always_comb begin
    a_c  = {15'd0, adct0_r[19:3]} - {15'd0, t1, 1'b0};
    b_c  = {16'd0, adct0_r[19:4]} - {16'd0, t1};
    bb_c = asr32(pb_r, 12);
    tf_c = v1_r + asr32(m_r, 14);
    t5_c = {tf3_r[29:0], 2'b00} + tf3_r + T_ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], take};
    end
  end

  // Payload advances every cycle; the valid chain marks the live stages.
  always_ff @(posedge clk) begin
    skip0_r <= (adcp == SKIP_CODE) || (adct == SKIP_CODE);
    adcp0_r <= adcp;
    adct0_r <= adct;
    skip1_r <= skip0_r;
    adcp1_r <= adcp0_r;
    pa_r    <= a_c * t2;
    pb_r    <= b_c * b_c;
    skip2_r <= skip1_r;
    adcp2_r <= adcp1_r;
    v1_r    <= asr32(pa_r, 11);
    m_r     <= bb_c * t3;
    skip3_r <= skip2_r;
    adcp3_r <= adcp2_r;
    tf3_r   <= tf_c;
    skip4_r <= skip3_r;
    adcp4_r <= adcp3_r;
    tf4_r   <= tf3_r;
    temp4_r <= asr32(t5_c, 8);
  end

  assign push      = v_r[4];
  assign item.skip = skip4_r;
  assign item.adcp = adcp4_r;
  assign item.tf   = tf4_r;
  assign item.temp = temp4_r;

endmodule

@@ hw/rtl/bpc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_queue - short queue between front and back
// Register-based circular buffer; the head entry is shown combinationally.
// ----------------------------------------------------------------------------
module bpc_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bpc_pkg::fq_item_t  push_data,
  input  logic               pop,
  output bpc_pkg::fq_item_t  pop_data,
  output logic               empty
);
  import bpc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fq_item_t        mem_r [DEPTH];
  logic [AW-1:0]   head_r, tail_r;
  logic [CW-1:0]   count_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) tail_r <= bump(tail_r);
      if (pop)  head_r <= bump(head_r);
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[tail_r] <= push_data;
  end

  assign pop_data = mem_r[head_r];
  assign empty    = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CW'(DEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

@@ hw/rtl/bpc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div - pipelined unsigned 64-bit divider
// One restoring quotient bit per stage, 64 stages, one division per cycle while en is high.
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [63:0]      in_num,
  input  logic [63:0]      in_den,
  input  bpc_pkg::side_t   in_side,
  output logic             out_vld,
  output logic [63:0]      out_quo,
  output bpc_pkg::side_t   out_side
);
  import bpc_pkg::*;

  logic [DIV_W-1:0] rem_r  [DIV_W];
  logic [DIV_W-1:0] dvd_r  [DIV_W];
  logic [DIV_W-1:0] quo_r  [DIV_W];
  logic [DIV_W-1:0] den_r  [DIV_W];
  side_t            side_r [DIV_W];
  logic [DIV_W-1:0] vld_r;

  logic [DIV_W-1:0] rem_nxt [DIV_W];
  logic [DIV_W-1:0] dvd_nxt [DIV_W];
  logic [DIV_W-1:0] quo_nxt [DIV_W];
  logic [DIV_W-1:0] den_nxt [DIV_W];
  side_t            side_nxt [DIV_W];

  always_comb begin
    logic [DIV_W-1:0] prem, pdvd, pquo, pden;
    logic [DIV_W:0]   trial;
    for (int s = 0; s < DIV_W; s++) begin
      if (s == 0) begin
        prem        = '0;
        pdvd        = in_num;
        pquo        = '0;
        pden        = in_den;
        side_nxt[s] = in_side;
      end else begin
        prem        = rem_r[s-1];
        pdvd        = dvd_r[s-1];
        pquo        = quo_r[s-1];
        pden        = den_r[s-1];
        side_nxt[s] = side_r[s-1];
      end
      trial = {prem, pdvd[DIV_W-1]} - {1'b0, pden};
      if (!trial[DIV_W]) begin
        rem_nxt[s] = trial[DIV_W-1:0];
        quo_nxt[s] = {pquo[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt[s] = {prem[DIV_W-2:0], pdvd[DIV_W-1]};
        quo_nxt[s] = {pquo[DIV_W-2:0], 1'b0};
      end
      dvd_nxt[s] = {pdvd[DIV_W-2:0], 1'b0};
      den_nxt[s] = pden;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_W; s++) begin
        rem_r[s]  <= rem_nxt[s];
        dvd_r[s]  <= dvd_nxt[s];
        quo_r[s]  <= quo_nxt[s];
        den_r[s]  <= den_nxt[s];
        side_r[s] <= side_nxt[s];
      end
    end
  end

  assign out_vld  = vld_r[DIV_W-1];
  assign out_quo  = quo_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

endmodule

@@ hw/rtl/bpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back - pressure path and result register
// Pulls items from the queue, runs the 64-bit pressure compensation through
// a stalling pipeline with the divider in its middle, and holds the result.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bpc_pkg::cal_t      cal,
  input  logic               q_empty,
  input  bpc_pkg::fq_item_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_temp,
  output logic [31:0]        out_press,
  output logic [1:0]         out_status
);
  import bpc_pkg::*;

  typedef struct packed {
    logic        skip;
    logic [31:0] temp;
  } ctl_t;

  logic        adv;
  logic [7:0]  bv_r;
  logic [4:0]  ev_r;
  logic        out_valid_r;

  fq_item_t           b0_r;
  ctl_t               c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic signed [32:0] v1_r;
  logic [20:0]        pp1_r, pp2_r, pp3_r, pp4_r;
  logic [63:0]        sq_r, m5_r, m2_r, m5b_r, m2b_r, t6_r, t3_r;
  logic [63:0]        v2_r, v1b_r, den5_r, num5_r, den6_r, num6_r;
  logic [63:0]        an_r, ad_r;
  side_t              s7_r;

  logic               dv_vld;
  logic [63:0]        dv_quo;
  side_t              dv_side;

  side_t              se0_r, se1_r, se2_r, se3_r, se4_r;
  logic [63:0]        qs0_r, qs1_r, qs2_r, qs3_r, q8p_r, q8_r, q8d_r, x_r, q9p_r, sum_r;
  mulp_t              xp_r;

  logic [63:0]        v1_c, pfin_c;
  logic signed [65:0] sq_c;
  logic signed [48:0] m5_c, m2_c;

  logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign p1 = cal.press_a[15:0];
  assign p2 = cal.press_a[31:16];
  assign p3 = cal.press_a[47:32];
  assign p4 = cal.press_a[63:48];
  assign p5 = cal.press_b[15:0];
  assign p6 = cal.press_b[31:16];
  assign p7 = cal.press_b[47:32];
  assign p8 = cal.press_b[63:48];
  assign p9 = cal.press_c;

  // Whole back pipeline moves together unless the result is held.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    v1_c   = {{32{b0_r.tf[31]}}, b0_r.tf} - P_FINE_OFS;
    sq_c   = v1_r * v1_r;
    m5_c   = v1_r * $signed(p5);
    m2_c   = v1_r * $signed(p2);
    pfin_c = asr64(sum_r, 8) + (sx16(p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      ev_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      bv_r        <= {bv_r[6:0], q_pop};
      ev_r        <= {ev_r[3:0], dv_vld};
      out_valid_r <= ev_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_r  <= q_data;
      c1_r  <= '{skip: b0_r.skip, temp: b0_r.temp};
      v1_r  <= v1_c[32:0];
      pp1_r <= P_FULL - {1'b0, b0_r.adcp};
      c2_r  <= c1_r;
      pp2_r <= pp1_r;
      sq_r  <= sq_c[63:0];
      m5_r  <= {{15{m5_c[48]}}, m5_c};
      m2_r  <= {{15{m2_c[48]}}, m2_c};
      c3_r  <= c2_r;
      pp3_r <= pp2_r;
      t6_r  <= mul64x16(sq_r, sx17(p6));
      t3_r  <= mul64x16(sq_r, sx17(p3));
      m5b_r <= m5_r;
      m2b_r <= m2_r;
      c4_r  <= c3_r;
      pp4_r <= pp3_r;
      v2_r  <= t6_r + (m5b_r << 17) + (sx16(p4) << 35);
      v1b_r <= asr64(t3_r, 8) + (m2b_r << 12);
      c5_r  <= c4_r;
      den5_r <= asr64(mul64x16(P_BIAS + v1b_r, {1'b0, p1}), 33);
      num5_r <= ({43'd0, pp4_r} << 31) - v2_r;
      c6_r   <= c5_r;
      den6_r <= den5_r;
      num6_r <= mul64x16(num5_r, P_SCALE);
      an_r   <= num6_r[63] ? (64'd0 - num6_r) : num6_r;
      ad_r   <= den6_r[63] ? (64'd0 - den6_r) : den6_r;
      s7_r   <= '{skip: c6_r.skip, dz: (den6_r == '0),
                  neg: num6_r[63] ^ den6_r[63], temp: c6_r.temp};
    end
  end

  bpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (bv_r[7]),
    .in_num   (an_r),
    .in_den   (ad_r),
    .in_side  (s7_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      se0_r <= dv_side;
      qs0_r <= dv_side.neg ? (64'd0 - dv_quo) : dv_quo;
      se1_r <= se0_r;
      qs1_r <= qs0_r;
      xp_r  <= mul_part(asr64(qs0_r, 13), asr64(qs0_r, 13));
      q8p_r <= mul64x16(qs0_r, sx17(p8));
      se2_r <= se1_r;
      qs2_r <= qs1_r;
      x_r   <= mul_join(xp_r);
      q8_r  <= asr64(q8p_r, 19);
      se3_r <= se2_r;
      qs3_r <= qs2_r;
      q9p_r <= mul64x16(x_r, sx17(p9));
      // hold q8 back one stage so it meets qs3 and q9p
      q8d_r <= q8_r;
      se4_r <= se3_r;
      sum_r <= qs3_r + asr64(q9p_r, 25) + q8d_r;
      if (se4_r.skip) begin
        out_temp   <= '0;
        out_press  <= '0;
        out_status <= ST_SKIP;
      end else if (se4_r.dz) begin
        out_temp   <= se4_r.temp;
        out_press  <= '0;
        out_status <= ST_ZERO;
      end else begin
        out_temp   <= se4_r.temp;
        out_press  <= pfin_c[31:0];
        out_status <= (pfin_c[31:0] == '0) ? ST_ZERO : ST_OK;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/baro_pressure_temp_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation - barometer integer compensation
// Raw 20-bit pressure and temperature samples in, temperature in 0.01 degC
// and Q24.8 pressure out, using twelve calibration words.
// ----------------------------------------------------------------------------
//
//   channel | direction | beat carries
//   --------+-----------+------------------------------------------------
//   in_     | in        | adc_pressure, adc_temperature (20 b each)
//   out_    | out       | temperature_centi, pressure_q24_8, status
//   cfg_    | in        | index 0..3, 64-bit data, write-only
//
// One beat enters per cycle while in_stall is low. From acceptance to its
// result a beat passes 5 front stages, one queue slot, 8 back stages, the
// 64-stage divider (one quotient bit a stage) and 6 post stages.
// in_stall rises when QDEPTH beats sit between the input and the back end.
// out_stall freezes the back end only; the queue soaks up the front end.
// rst_n is synchronous, active low, and clears calibration to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation #(
  parameter int QDEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_adc_pressure,
  input  logic [19:0]        in_adc_temperature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic [1:0]         out_status,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import bpc_pkg::*;

  // Credit counter covers the front stages and the queue together.
  localparam int CW = $clog2(QDEPTH + 1);

  cal_t          cal_r;
  logic [CW-1:0] credit_r, credit_nxt;
  logic          take;
  logic          push, pop, q_empty;
  fq_item_t      f_item, q_item;
  logic [31:0]   temp_w;

  // Calibration registers: user writes only while block is idle; block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP:    cal_r.temp_cal <= cfg_wdata[47:0];
        CFG_PRESS_A: cal_r.press_a  <= cfg_wdata;
        CFG_PRESS_B: cal_r.press_b  <= cfg_wdata;
        CFG_PRESS_C: cal_r.press_c  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Accept while credit remains; release a credit when the back end pops.
  assign in_stall   = (credit_r == CW'(QDEPTH));
  assign take       = in_valid && !in_stall;
  assign credit_nxt = credit_r + CW'(take) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  bpc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .adcp  (in_adc_pressure),
    .adct  (in_adc_temperature),
    .cal   (cal_r),
    .push  (push),
    .item  (f_item)
  );

  bpc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (f_item),
    .pop       (pop),
    .pop_data  (q_item),
    .empty     (q_empty)
  );

  bpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal_r),
    .q_empty    (q_empty),
    .q_data     (q_item),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_temp   (temp_w),
    .out_press  (out_pressure_q24_8),
    .out_status (out_status)
  );

  assign out_temperature_centi = $signed(temp_w);

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CW'(QDEPTH))
    else $error("credit count beyond queue depth");

endmodule

@@ bench/baro_comp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_comp_checker - compensation predictor and result scoreboard
// Tracks calibration writes, predicts temperature, pressure and status for
// every accepted input beat, and compares result beats in order.
// ----------------------------------------------------------------------------
module baro_comp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [19:0] in_adc_pressure,
  input  logic [19:0] in_adc_temperature,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_temperature_centi,
  input  logic [31:0] out_pressure_q24_8,
  input  logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          mismatch_count,
  output int          pending_count
);
  import bpc_pkg::*;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [1:0]  status;
  } comp_result_t;

  logic [47:0] cal_t_word;
  logic [63:0] cal_pa_word;
  logic [63:0] cal_pb_word;
  logic [15:0] cal_pc_word;

  comp_result_t expected_results[$];

  function automatic logic signed [63:0] sdiv_trunc(input logic signed [63:0] n,
                                                    input logic signed [63:0] d);
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q  = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(input logic [19:0] adcp,
                                              input logic [19:0] adct);
    comp_result_t r;
    logic signed [31:0] a, b, v1t, v2t, tf, sq;
    logic signed [63:0] t1, t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, q9, q8;
    if (adcp == SKIP_CODE || adct == SKIP_CODE) begin
      r.temp = '0; r.press = '0; r.status = ST_SKIP;
      return r;
    end
    t1 = {48'd0, cal_t_word[15:0]};
    t2 = {{48{cal_t_word[31]}}, cal_t_word[31:16]};
    t3 = {{48{cal_t_word[47]}}, cal_t_word[47:32]};
    p1 = {48'd0, cal_pa_word[15:0]};
    p2 = {{48{cal_pa_word[31]}}, cal_pa_word[31:16]};
    p3 = {{48{cal_pa_word[47]}}, cal_pa_word[47:32]};
    p4 = {{48{cal_pa_word[63]}}, cal_pa_word[63:48]};
    p5 = {{48{cal_pb_word[15]}}, cal_pb_word[15:0]};
    p6 = {{48{cal_pb_word[31]}}, cal_pb_word[31:16]};
    p7 = {{48{cal_pb_word[47]}}, cal_pb_word[47:32]};
    p8 = {{48{cal_pb_word[63]}}, cal_pb_word[63:48]};
    p9 = {{48{cal_pc_word[15]}}, cal_pc_word};
    // temperature path wraps at 32 bits
    a   = 32'({12'd0, adct} >> 3) - 32'(t1 << 1);
    v1t = (a * 32'(t2)) >>> 11;
    b   = 32'({12'd0, adct} >> 4) - 32'(t1);
    sq  = (b * b) >>> 12;
    v2t = (sq * 32'(t3)) >>> 14;
    tf  = v1t + v2t;
    r.temp = (tf * 32'sd5 + 32'sd128) >>> 8;
    // pressure path wraps at 64 bits
    v1 = 64'(tf) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.press = '0; r.status = ST_ZERO;
      return r;
    end
    p  = 64'sd1048576 - 64'(adcp);
    p  = sdiv_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
    q9 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
    q8 = (p8 * p) >>> 19;
    p  = ((p + q9 + q8) >>> 8) + (p7 <<< 4);
    r.press  = p[31:0];
    r.status = (p[31:0] == 0) ? ST_ZERO : ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    comp_result_t want;
    if (!rst_n) begin
      cal_t_word  <= '0;
      cal_pa_word <= '0;
      cal_pb_word <= '0;
      cal_pc_word <= '0;
      mismatch_count <= 0;
      pending_count  <= 0;
      expected_results.delete();
    end else begin
      // predict with the calibration in force before this edge's write
      if (in_valid && !in_stall)
        expected_results.push_back(compensate(in_adc_pressure, in_adc_temperature));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result beat", $time);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.temp !== out_temperature_centi || want.press !== out_pressure_q24_8 ||
              want.status !== out_status) begin
            if (mismatch_count < 10)
              $display("%0t: temp exp %0d got %0d, press exp %h got %h, status exp %0d got %0d",
                       $time, $signed(want.temp), $signed(out_temperature_centi),
                       want.press, out_pressure_q24_8, want.status, out_status);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending_count <= expected_results.size();
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEMP:    cal_t_word  <= cfg_wdata[47:0];
          CFG_PRESS_A: cal_pa_word <= cfg_wdata;
          CFG_PRESS_B: cal_pb_word <= cfg_wdata;
          CFG_PRESS_C: cal_pc_word <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/tb_baro_pressure_temp_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation - barometer compensation testbench
// Drives directed and random sample beats through several calibration sets
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation;
  import bpc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [19:0] in_adc_pressure;
  logic [19:0] in_adc_temperature;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_temperature_centi;
  logic [31:0] out_pressure_q24_8;
  logic [1:0]  out_status;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          mismatch_count;
  int          pending_count;
  int          cycle_count;
  bit          calm_phase;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 200;

  baro_pressure_temp_compensation uut (.*);

  baro_comp_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: stall in bursts, none in the calm phase
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm_phase && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // write one calibration register while the block is idle
  task automatic write_cal(input cfg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // drop valid, hold until the checker has nothing pending, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // send one beat; hold it until accepted, optionally with an idle gap first.
  // Valid stays high on return so the next beat can follow with no gap.
  task automatic send_sample(input logic [19:0] adcp, input logic [19:0] adct);
    int gap;
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_adc_pressure    <= adcp;
    in_adc_temperature <= adct;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // pick an ADC value: half plausible, the rest extremes, the skip code or raw noise
  function automatic logic [19:0] pick_adc(input logic [19:0] centre);
    case ($urandom_range(0, 9))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      2: return SKIP_CODE;
      3, 4: return 20'($urandom);
      default: return centre + 20'($urandom_range(0, 131071)) - 20'd65536;
    endcase
  endfunction

  task automatic load_cal(input logic [63:0] t, input logic [63:0] a,
                          input logic [63:0] b, input logic [63:0] c);
    write_cal(CFG_TEMP, t);
    write_cal(CFG_PRESS_A, a);
    write_cal(CFG_PRESS_B, b);
    write_cal(CFG_PRESS_C, c);
  endtask

  initial begin
    logic [63:0] typical_t, typical_a, typical_b, typical_c;
    in_valid = 1'b0;
    in_adc_pressure = '0;
    in_adc_temperature = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_TEMP;
    cfg_wdata = '0;
    cycle_count = 0;
    calm_phase = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // all-zero calibration: a plain sample lands on the zero divisor case, a skip sample on skip
    send_sample(20'h65432, 20'h7ABCD);
    send_sample(SKIP_CODE, 20'h7ABCD);
    drain_results();

    // typical datasheet-like calibration
    typical_t = {16'h0000, 16'hFC18, 16'h6A2A, 16'h6B6B};   // T3=-1000, T2, T1
    typical_a = {16'h1E37, 16'h0C43, 16'hD5D8, 16'h8E3A};
    typical_b = {16'hC3E8, 16'h1E00, 16'hFFF9, 16'h008C};
    typical_c = 64'h0000_0000_0000_1770;
    load_cal(typical_t, typical_a, typical_b, typical_c);
    send_sample(20'h65A3C, 20'h7E1B0);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(SKIP_CODE, 20'h7E1B0);
    send_sample(20'h65A3C, SKIP_CODE);
    send_sample(SKIP_CODE, SKIP_CODE);
    send_sample(20'h7FFFF, 20'h80001);
    send_sample(20'h80001, 20'h7FFFF);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    drain_results();

    // pressure at exactly zero: P4 cancels the numerator, P7 is zero
    load_cal(64'h0, 64'h0001_0000_0000_0001, 64'h0, 64'h0);
    send_sample(20'hFFFF0, 20'h7E1B0);
    drain_results();

    // random phases over several calibration sets, extremes included
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_cal(typical_t, typical_a, typical_b, typical_c);
        1: load_cal(64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FFFF);
        2: load_cal({16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                    {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                    {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF);
        3: load_cal({16'h0000, 16'h8000, 16'h8000, 16'h0001},
                    {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                    {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
        default: load_cal({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      // last phase runs with no idling on either side
      if (phase == 7) calm_phase = 1'b1;
      for (int n = 0; n < 190; n++)
        send_sample(pick_adc(20'h65A3C), pick_adc(20'h7E1B0));
      drain_results();
    end

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
